FILE: src/tmbq_pkg.sv
// Package for the tile map blend query block: field widths, operation and
// result codes, neighbour order and coordinate helpers.
// No dependencies.
`timescale 1ns / 1ps

package tmbq_pkg;

   localparam int MAX_SIDE_DEF     = 128;
   localparam int TERRAIN_BITS_DEF = 8;

   // Fixed widths of the stream fields
   localparam int OP_W      = 2;
   localparam int COORD_W   = 16;
   localparam int CODE_IN_W = 8;
   localparam int OUTER_W   = 7;
   localparam int CODE_W    = 8;
   localparam int SIDE_W    = 8;

   localparam int REQ_DATA_W = 40;   // x, y, terrain_in = 40 bits
   localparam int RSP_DATA_W = 24;   // outer_x, outer_y, terrain_out = 22 bits, padded
   localparam int RSP_USER_W = 2;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd128;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_BLEND = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_BLEND = 1'b1;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } offset_type;

   typedef struct packed {
      logic signed [COORD_W:0] x;
      logic signed [COORD_W:0] y;
   } coord_type;

   // Neighbour visiting order: dx outer, dy inner, centre skipped
   function automatic offset_type nbr_off(input logic [2:0] idx);
      offset_type o;
      unique case (idx)
         3'd0: o = '{dx: -2'sd1, dy: -2'sd1};
         3'd1: o = '{dx: -2'sd1, dy:  2'sd0};
         3'd2: o = '{dx: -2'sd1, dy:  2'sd1};
         3'd3: o = '{dx:  2'sd0, dy: -2'sd1};
         3'd4: o = '{dx:  2'sd0, dy:  2'sd1};
         3'd5: o = '{dx:  2'sd1, dy: -2'sd1};
         3'd6: o = '{dx:  2'sd1, dy:  2'sd0};
         3'd7: o = '{dx:  2'sd1, dy:  2'sd1};
         default: o = '{dx: 2'sd0, dy: 2'sd0};
      endcase
      return o;
   endfunction

   function automatic coord_type shift_coord(input logic signed [COORD_W-1:0] x,
                                             input logic signed [COORD_W-1:0] y,
                                             input offset_type o);
      coord_type c;
      c.x = (COORD_W+1)'(x) + (COORD_W+1)'(o.dx);
      c.y = (COORD_W+1)'(y) + (COORD_W+1)'(o.dy);
      return c;
   endfunction

   function automatic logic in_map(input coord_type c, input logic [COORD_W-1:0] side);
      return !c.x[COORD_W] && !c.y[COORD_W] &&
             (c.x[COORD_W-1:0] < side) && (c.y[COORD_W-1:0] < side);
   endfunction

endpackage

FILE: src/tmbq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tmbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

FILE: src/tile_map_blend_query.sv
// Write: stores an in-map tile in the load state, no result. Read: load, read,
// result states to the result register. Blend query: centre plus eight
// neighbours, one tile memory read a cycle, then one emitted line a cycle unless
// the response stream stalls. One item in flight at a time; requests are taken only when idle.
// Synchronous active-high reset clears the sequencer, result valid and map_side
// (to 128); tiles are undefined until written. Depends on tmbq_pkg and tmbq_ram.
`timescale 1ns / 1ps

module tile_map_blend_query
   import tmbq_pkg::*;
#(
   parameter int MAX_SIDE     = MAX_SIDE_DEF,
   parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // tile_x[15:0], tile_y[31:16], terrain_in[39:32]
   input  logic [OP_W-1:0]       req_tuser,  // op[1:0]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // outer_x[6:0], outer_y[13:7], terrain_out[21:14]
   output logic [RSP_USER_W-1:0] rsp_tuser,  // kind[0], is_none[1]
   output logic                  rsp_tlast,
   // map_side register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIDE_W-1:0]     csr_data
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_SIDE);
   localparam int SW    = $clog2(MAX_SIDE + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_RESULT = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   localparam logic [3:0] SCAN_LAST = 4'd9;

   logic [2:0]                state_ff, state_in;
   logic [SIDE_W-1:0]         map_side_ff;
   logic [OP_W-1:0]           op_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [TERRAIN_BITS-1:0]   code_ff;
   logic [3:0]                cnt_ff, cnt_in;
   logic [TERRAIN_BITS-1:0]   centre_ff, centre_in;
   logic [7:0]                hits_ff, hits_in;
   logic [TERRAIN_BITS-1:0]   res_code_ff, res_code_in;
   logic                      res_none_ff, res_none_in;

   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff, rsp_none_ff, rsp_last_ff;
   logic [OUTER_W-1:0]        rsp_ox_ff, rsp_oy_ff;
   logic [CODE_W-1:0]         rsp_code_ff;

   logic                      out_load, out_kind, out_none, out_last;
   logic [OUTER_W-1:0]        out_ox, out_oy;
   logic [CODE_W-1:0]         out_code;

   logic [SW-1:0]             side_eff;
   logic [COORD_W-1:0]        side16;
   coord_type                 issue_c, cap_c, emit_c;
   logic [2:0]                issue_idx, cap_idx, pick;
   logic                      issue_inb;
   logic [7:0]                hits_rest;

   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [TERRAIN_BITS-1:0]   ram_rdata;

   function automatic logic [AW-1:0] tile_addr(input coord_type c, input logic [SW-1:0] s);
      return AW'(c.x[XW-1:0]) + AW'(c.y[XW-1:0]) * AW'(s);
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      if (32'(map_side_ff) > 32'(MAX_SIDE)) begin
         side_eff = SW'(MAX_SIDE);
      end else begin
         side_eff = SW'(map_side_ff);
      end
   end
   assign side16 = COORD_W'(side_eff);

   // Read issue: centre in the load cycle, neighbour cnt-1 while scanning
   assign issue_idx = 3'(cnt_ff - 4'd1);
   assign issue_c   = (state_ff == S_SCAN) ? shift_coord(x_ff, y_ff, nbr_off(issue_idx))
                                           : shift_coord(x_ff, y_ff, '0);
   assign issue_inb = in_map(issue_c, side16);
   assign ram_addr  = tile_addr(issue_c, side_eff);
   assign ram_we    = (state_ff == S_LOAD) && (op_ff == OP_WRITE) && issue_inb;

   // Data returning this cycle belongs to neighbour cnt-2
   assign cap_idx = 3'(cnt_ff - 4'd2);
   assign cap_c   = shift_coord(x_ff, y_ff, nbr_off(cap_idx));

   always_comb begin
      pick = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (hits_ff[i]) begin
            pick = 3'(i);
         end
      end
   end
   assign emit_c    = shift_coord(x_ff, y_ff, nbr_off(pick));
   assign hits_rest = hits_ff & ~(8'd1 << pick);

   tmbq_ram #(
      .WIDTH (TERRAIN_BITS),
      .DEPTH (DEPTH)
   ) u_tiles (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (code_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      centre_in   = centre_ff;
      hits_in     = hits_ff;
      res_code_in = res_code_ff;
      res_none_in = res_none_ff;
      out_load    = 1'b0;
      out_kind    = KIND_READ;
      out_ox      = '0;
      out_oy      = '0;
      out_code    = '0;
      out_none    = 1'b0;
      out_last    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cnt_in  = 4'd1;
            hits_in = '0;
            if (op_ff == OP_READ) begin
               if (issue_inb) begin
                  state_in = S_READ;
               end else begin
                  res_code_in = '0;
                  res_none_in = 1'b1;
                  state_in    = S_RESULT;
               end
            end else if (op_ff == OP_BLEND && issue_inb) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            res_code_in = ram_rdata;
            res_none_in = 1'b0;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               out_code = CODE_W'(res_code_ff);
               out_none = res_none_ff;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (cnt_ff == 4'd1) begin
               centre_in = ram_rdata;
            end else if (in_map(cap_c, side16) && (ram_rdata < centre_ff)) begin
               hits_in[cap_idx] = 1'b1;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == SCAN_LAST) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (hits_ff == '0) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               out_kind = KIND_BLEND;
               out_ox   = OUTER_W'(emit_c.x);
               out_oy   = OUTER_W'(emit_c.y);
               out_code = CODE_W'(centre_ff);
               out_last = (hits_rest == '0);
               hits_in  = hits_rest;
               if (hits_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_side_ff  <= SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            map_side_ff <= csr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         x_ff    <= req_tdata[15:0];
         y_ff    <= req_tdata[31:16];
         code_ff <= TERRAIN_BITS'(req_tdata[39:32]);
      end
      cnt_ff      <= cnt_in;
      centre_ff   <= centre_in;
      hits_ff     <= hits_in;
      res_code_ff <= res_code_in;
      res_none_ff <= res_none_in;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_ox_ff   <= out_ox;
         rsp_oy_ff   <= out_oy;
         rsp_code_ff <= out_code;
         rsp_none_ff <= out_none;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_code_ff, rsp_oy_ff, rsp_ox_ff};
   assign rsp_tuser  = {rsp_none_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
